// ===== hdl/ppf_pkg.sv =====
// Shared types and constants for the programmable probabilistic state machine.
`default_nettype none
package ppf_pkg;
  localparam int NumStates = 64;
  localparam int NumTrans  = 256;
  localparam int StBits    = 6;
  localparam int TrBits    = 8;
  localparam int CntBits   = 9;

  typedef enum logic [1:0] {
    CMD_DATA    = 2'd0,
    CMD_LOAD_TR = 2'd1,
    CMD_LOAD_ST = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    MK_ANY_NUM = 3'd0,
    MK_NUM     = 3'd1,
    MK_RANGE   = 3'd2,
    MK_ANY_SYM = 3'd3,
    MK_SYM     = 3'd4,
    MK_SPECIAL = 3'd5
  } match_kind_e;

  localparam logic [1:0] KindNumber  = 2'd0;
  localparam logic [1:0] KindSymbol  = 2'd1;
  localparam logic [1:0] KindSpecial = 2'd2;

  // configuration register indexes
  localparam logic [1:0] RegRunning     = 2'd0;
  localparam logic [1:0] RegAutoRestart = 2'd1;
  localparam logic [1:0] RegStartState  = 2'd2;

  localparam logic [15:0] LfsrSeed = 16'hACE1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STATE_RD,
    S_TR_RD,
    S_TR_EVAL,
    S_FLAG_RD,
    S_OUT
  } ctl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch input transaction
    logic do_load;    // perform table load or restart
    logic state_rd;   // read state table at current state
    logic tr_rd;      // read transition at scan index
    logic tr_take;    // take evaluated transition, read target flags
    logic tr_next;    // advance scan
    logic finish;     // finalize result (flags read done)
    logic fail;       // finalize as failure
    logic out_load;   // load output register
  } ppf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_data;
    logic can_run;    // running and state valid
    logic scan_done;  // no transitions left
    logic hit;        // evaluated transition is taken
  } ppf_sts_t;
endpackage
`default_nettype wire

// ===== hdl/ppf_ctrl.sv =====
// Controller state machine sequencing loads and the transition scan.
`default_nettype none
module ppf_ctrl import ppf_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire logic     out_busy_i,
  input  ppf_sts_t      sts_i,
  output ppf_cmd_t      cmd_o
);
  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_STATE_RD;
      S_STATE_RD: begin
        if (!sts_i.is_data || !sts_i.can_run) state_d = S_OUT;
        else state_d = S_TR_RD;
      end
      S_TR_RD:    state_d = sts_i.scan_done ? S_OUT : S_TR_EVAL;
      S_TR_EVAL:  state_d = sts_i.hit ? S_FLAG_RD : S_TR_RD;
      S_FLAG_RD:  state_d = S_OUT;
      S_OUT:      if (!out_busy_i) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE:     cmd_o.capture = in_valid_i;
      S_STATE_RD: begin
        cmd_o.do_load  = !sts_i.is_data;
        cmd_o.state_rd = sts_i.is_data && sts_i.can_run;
        cmd_o.fail     = sts_i.is_data && !sts_i.can_run;
      end
      S_TR_RD: begin
        cmd_o.tr_rd    = !sts_i.scan_done;
        cmd_o.fail     = sts_i.scan_done;
      end
      S_TR_EVAL: begin
        cmd_o.tr_take = sts_i.hit;
        cmd_o.tr_next = !sts_i.hit;
      end
      S_FLAG_RD:  cmd_o.finish = 1'b1;
      S_OUT:      cmd_o.out_load = !out_busy_i;
      default:    ;
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/ppf_datapath.sv =====
// Tables, LFSR, transition matcher and result registers.
`default_nettype none
module ppf_datapath import ppf_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  ppf_cmd_t               cmd_i,
  output ppf_sts_t               sts_o,
  input  wire logic              running_i,
  input  wire logic              auto_restart_i,
  input  wire logic [StBits-1:0] start_state_i,
  input  wire logic [1:0]        cmd_i_f,
  input  wire logic [1:0]        item_kind_i,
  input  wire logic signed [31:0] item_value_i,
  input  wire logic signed [31:0] upper_value_i,
  input  wire logic [7:0]        entry_index_i,
  input  wire logic [2:0]        match_kind_i,
  input  wire logic [1:0]        flag_bits_i,
  input  wire logic              random_on_i,
  input  wire logic [14:0]       chance_i,
  input  wire logic [5:0]        target_state_i,
  input  wire logic [7:0]        first_transition_i,
  input  wire logic [8:0]        transition_count_i,
  output logic                   res_matched_o,
  output logic [7:0]             res_tidx_o,
  output logic [5:0]             res_state_o,
  output logic                   res_valid_o,
  output logic                   res_stop_o,
  output logic                   res_fail_o
);
  // captured transaction
  logic [1:0]  cmd_q, kind_q, flags_q;
  logic signed [31:0] val_q, up_q;
  logic [7:0]  eidx_q, first_q;
  logic [2:0]  mk_q;
  logic        rnd_q;
  logic [14:0] chance_q;
  logic [5:0]  tgt_q;
  logic [8:0]  cnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= cmd_i_f;       kind_q <= item_kind_i;  val_q <= item_value_i;
      up_q <= upper_value_i;  eidx_q <= entry_index_i; mk_q <= match_kind_i;
      flags_q <= flag_bits_i; rnd_q <= random_on_i;   chance_q <= chance_i;
      tgt_q <= target_state_i; first_q <= first_transition_i;
      cnt_q <= transition_count_i;
    end
  end

  // memories
  logic [18:0] st_mem [NumStates];
  logic [63:0] bnd_mem [NumTrans];
  logic [26:0] ctl_mem [NumTrans];
  logic [18:0] st_rd_q;
  logic [63:0] bnd_rd_q;
  logic [26:0] ctl_rd_q;

  logic [StBits-1:0] cur_q;
  logic              cur_valid_q;
  logic [TrBits-1:0] idx_q;
  logic [CntBits-1:0] left_q;

  logic st_we, tr_we;
  assign tr_we = cmd_i.do_load && (cmd_q == CMD_LOAD_TR);
  assign st_we = cmd_i.do_load && (cmd_q == CMD_LOAD_ST) && (eidx_q < 8'(NumStates));

  logic [StBits-1:0] st_raddr;
  always_comb begin
    st_raddr = cur_q;
    if (cmd_i.tr_take) st_raddr = ctl_rd_q[5:0];
  end

  always_ff @(posedge clk_i) begin
    if (st_we) st_mem[eidx_q[StBits-1:0]] <= {flags_q, first_q, cnt_q};
    if (cmd_i.state_rd || cmd_i.tr_take) st_rd_q <= st_mem[st_raddr];
  end

  // scan counters; first/count come from st_rd_q the cycle after state_rd
  logic scan_init_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) scan_init_q <= 1'b0;
    else         scan_init_q <= cmd_i.state_rd;
  end

  logic [CntBits-1:0] cnt_sat;
  assign cnt_sat = (st_rd_q[8:0] > 9'(NumTrans)) ? 9'(NumTrans) : st_rd_q[8:0];

  logic [CntBits-1:0] left_now;
  logic [TrBits-1:0]  idx_now;
  assign left_now = scan_init_q ? cnt_sat : left_q;
  assign idx_now  = scan_init_q ? st_rd_q[16:9] : idx_q;

  always_ff @(posedge clk_i) begin
    if (tr_we) begin
      bnd_mem[eidx_q] <= {up_q, val_q};
      ctl_mem[eidx_q] <= {mk_q, flags_q, rnd_q, chance_q, tgt_q};
    end
    if (cmd_i.tr_rd) begin
      bnd_rd_q <= bnd_mem[idx_now];
      ctl_rd_q <= ctl_mem[idx_now];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tr_rd) begin
      left_q <= left_now - 9'd1;
      idx_q  <= idx_now + 8'd1;
    end else if (scan_init_q) begin
      left_q <= cnt_sat;
      idx_q  <= st_rd_q[16:9];
    end
  end

  // index of the transition being evaluated
  logic [TrBits-1:0] tidx_q;
  always_ff @(posedge clk_i) if (cmd_i.tr_rd) tidx_q <= idx_now;

  // matcher
  logic [2:0]  t_mk;
  logic [1:0]  t_fl;
  logic        t_rnd;
  logic [14:0] t_ch;
  logic signed [31:0] t_lo, t_hi;
  assign {t_mk, t_fl, t_rnd, t_ch} = ctl_rd_q[26:6];
  assign t_lo = bnd_rd_q[31:0];
  assign t_hi = bnd_rd_q[63:32];

  logic kind_hit;
  always_comb begin
    kind_hit = 1'b0;
    case (kind_q)
      KindNumber: begin
        case (t_mk)
          MK_ANY_NUM: kind_hit = 1'b1;
          MK_NUM:     kind_hit = (t_lo == val_q);
          MK_RANGE:   kind_hit = (t_fl[0] || t_lo <= val_q) && (t_fl[1] || t_hi >= val_q);
          default:    kind_hit = 1'b0;
        endcase
      end
      KindSymbol: begin
        case (t_mk)
          MK_ANY_SYM: kind_hit = 1'b1;
          MK_SYM:     kind_hit = (t_lo == val_q);
          default:    kind_hit = 1'b0;
        endcase
      end
      KindSpecial: kind_hit = (t_mk == MK_SPECIAL) && (t_lo == val_q);
      default:     kind_hit = 1'b0;
    endcase
  end

  logic [15:0] lfsr_q, lfsr_nx;
  assign lfsr_nx = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
  logic draw_ok, hit, eval_q;
  assign draw_ok = lfsr_nx[14:0] < t_ch;
  assign hit = kind_hit && (!t_rnd || draw_ok);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) lfsr_q <= LfsrSeed;
    else if ((cmd_i.tr_take || cmd_i.tr_next) && kind_hit && t_rnd) lfsr_q <= lfsr_nx;
  end

  // machine state and result
  logic [StBits-1:0] tgt_hold_q;
  always_ff @(posedge clk_i) if (cmd_i.tr_take) tgt_hold_q <= ctl_rd_q[5:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0; cur_valid_q <= 1'b0;
      res_matched_o <= 1'b0; res_tidx_o <= '0; res_stop_o <= 1'b0; res_fail_o <= 1'b0;
      eval_q <= 1'b0;
    end else begin
      eval_q <= cmd_i.tr_rd;
      if (cmd_i.capture) begin
        res_matched_o <= 1'b0; res_tidx_o <= '0; res_stop_o <= 1'b0; res_fail_o <= 1'b0;
      end
      if (cmd_i.do_load && cmd_q == CMD_RESTART) begin
        cur_q <= start_state_i; cur_valid_q <= 1'b1;
      end
      if (cmd_i.fail) begin
        res_fail_o <= 1'b1; cur_valid_q <= 1'b0; cur_q <= '0;
      end
      if (cmd_i.tr_take) begin
        res_matched_o <= 1'b1; res_tidx_o <= tidx_q;
      end
      if (cmd_i.finish) begin
        res_stop_o <= |st_rd_q[18:17];
        cur_q <= (st_rd_q[18] && auto_restart_i) ? start_state_i : tgt_hold_q;
      end
    end
  end

  assign res_state_o = cur_valid_q ? cur_q : '0;
  assign res_valid_o = cur_valid_q;

  assign sts_o.is_data   = (cmd_q == CMD_DATA);
  assign sts_o.can_run   = running_i && cur_valid_q;
  assign sts_o.scan_done = (left_now == '0);
  assign sts_o.hit       = hit && eval_q;
endmodule
`default_nettype wire

// ===== hdl/programmable_probabilistic_fsm.sv =====
// Top level of the programmable probabilistic state machine.
// Each transaction yields one result. Loads and restart pass from capture and
// the state-read step straight to the output register, and so does a data item
// refused by a stopped machine or an invalid state; a data item takes one
// memory read and one evaluate step per transition scanned, then a read of the
// target state's flags when a transition is taken or the end-of-list check when
// none is. One transaction is in work at a time; the next is accepted once the
// result has moved into the output register. Tables are undefined until loaded.
`default_nettype none
module programmable_probabilistic_fsm import ppf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [5:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [1:0]  item_kind_i,
  input  wire logic signed [31:0] item_value_i,
  input  wire logic signed [31:0] upper_value_i,
  input  wire logic [7:0]  entry_index_i,
  input  wire logic [2:0]  match_kind_i,
  input  wire logic [1:0]  flag_bits_i,
  input  wire logic        random_on_i,
  input  wire logic [14:0] chance_i,
  input  wire logic [5:0]  target_state_i,
  input  wire logic [7:0]  first_transition_i,
  input  wire logic [8:0]  transition_count_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             matched_o,
  output logic [7:0]       transition_index_o,
  output logic [5:0]       new_state_o,
  output logic             state_valid_o,
  output logic             stop_pulse_o,
  output logic             fail_pulse_o
);
  logic running_q, auto_restart_q;
  logic [5:0] start_state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0; auto_restart_q <= 1'b0; start_state_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegRunning:     running_q <= cfg_data_i[0];
        RegAutoRestart: auto_restart_q <= cfg_data_i[0];
        RegStartState:  start_state_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ppf_cmd_t cmd;
  ppf_sts_t sts;
  logic out_busy;
  assign out_busy = out_valid_o && out_stall_i;

  logic r_m, r_v, r_s, r_f;
  logic [7:0] r_t;
  logic [5:0] r_st;

  ppf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .out_busy_i(out_busy), .sts_i(sts), .cmd_o(cmd)
  );

  ppf_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .running_i(running_q), .auto_restart_i(auto_restart_q), .start_state_i(start_state_q),
    .cmd_i_f(cmd_i), .item_kind_i, .item_value_i, .upper_value_i, .entry_index_i,
    .match_kind_i, .flag_bits_i, .random_on_i, .chance_i, .target_state_i,
    .first_transition_i, .transition_count_i,
    .res_matched_o(r_m), .res_tidx_o(r_t), .res_state_o(r_st), .res_valid_o(r_v),
    .res_stop_o(r_s), .res_fail_o(r_f)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (cmd.out_load) out_valid_o <= 1'b1;
    else if (!out_stall_i) out_valid_o <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      matched_o <= r_m; transition_index_o <= r_t; new_state_o <= r_st;
      state_valid_o <= r_v; stop_pulse_o <= r_s; fail_pulse_o <= r_f;
    end
  end
endmodule
`default_nettype wire
